// ===== src/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Operation and status codes, and the command and status bundles that pass
// between the queue controller and the queue datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int OP_W     = 3;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_WALK_FWD   = 3'd4;
   localparam logic [OP_W-1:0] OP_WALK_BACK  = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic start;   // take the operation at the request ports
      logic emit;    // load the result register with the pending word
   } dq_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic op_known;   // request carries a defined operation code
      logic more;       // a walk has further words after the pending one
   } dq_stat_type;

endpackage

// ===== src/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer for the queue: takes one operation, then emits its result words
// into the output register one at a time.
// ----------------------------------------------------------------------------
module dq_ctrl
   import dq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output dq_cmd_type  cmd,
   input  dq_stat_type dp_status
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.start    = 1'b0;
      cmd.emit     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // undefined codes are taken and dropped
            if (req_valid && dp_status.op_known) begin
               cmd.start = 1'b1;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               if (!dp_status.more) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_idle_no_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !dp_status.more)
      else $error("walk still pending while controller is idle");
`endif

endmodule

// ===== src/dq_datapath.sv =====
// ----------------------------------------------------------------------------
// dq_datapath
// Circular slot memory with front pointer and fill count, the registered
// memory read, the walk position counter and the result register.
// ----------------------------------------------------------------------------
module dq_datapath
   import dq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dq_cmd_type                             cmd,
   output dq_stat_type                            dp_status,
   input  logic [OP_W-1:0]                        req_operation,
   input  logic signed [VAL_W-1:0]                req_value,
   output logic signed [VAL_W-1:0]                rsp_value_res,
   output logic                                   rsp_last,
   output logic [STATUS_W-1:0]                    rsp_status,
   output logic [$clog2(CAPACITY+1)-1:0]          rsp_entry_count
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [VAL_W-1:0]    slot_mem_ff [CAPACITY];
   logic [VAL_W-1:0]    rd_data_ff;
   logic [IDX_W-1:0]    front_ff, front_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                walk_ff, walk_in;
   logic                back_ff;
   logic [IDX_W-1:0]    walk_pos_ff, walk_pos_in;
   logic [STATUS_W-1:0] pend_status_ff, pend_status_in;
   logic                pend_mem_ff, pend_mem_in;

   logic [VAL_W-1:0]    out_value_ff;
   logic                out_last_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic [CNT_W-1:0]    out_count_ff;

   logic                is_push, is_pop, is_walk, is_back;
   logic                full, empty, pos_last;
   logic [IDX_W-1:0]    front_dec, front_inc;
   logic [IDX_W-1:0]    back_addr, tail_addr, step_addr, start_addr;
   logic [CNT_W-1:0]    step_off;
   logic                wr_en, rd_en;
   logic [IDX_W-1:0]    wr_addr, rd_addr;

   // front + offset, folded back into the ring (sum stays below 2*CAPACITY)
   function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W:0] sum);
      logic [IDX_W:0] folded;
      folded = sum;
      if (sum >= (IDX_W+1)'(CAPACITY)) begin
         folded = sum - (IDX_W+1)'(CAPACITY);
      end
      return folded[IDX_W-1:0];
   endfunction

   assign is_push = (req_operation == OP_PUSH_FRONT) || (req_operation == OP_PUSH_BACK);
   assign is_pop  = (req_operation == OP_POP_FRONT) || (req_operation == OP_POP_BACK);
   assign is_walk = (req_operation == OP_WALK_FWD) || (req_operation == OP_WALK_BACK);
   assign is_back = (req_operation == OP_POP_BACK) || (req_operation == OP_WALK_BACK);

   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   assign front_dec = (front_ff == '0) ? IDX_W'(CAPACITY - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == IDX_W'(CAPACITY - 1)) ? '0 : front_ff + 1'b1;

   assign back_addr  = wrap({1'b0, front_ff} + (IDX_W+1)'(count_ff - 1'b1));
   assign tail_addr  = wrap({1'b0, front_ff} + (IDX_W+1)'(count_ff));
   assign start_addr = is_back ? back_addr : front_ff;

   assign pos_last = (CNT_W'(walk_pos_ff) == count_ff - 1'b1);
   assign step_off = back_ff ? count_ff - CNT_W'(walk_pos_ff) - CNT_W'(2)
                             : CNT_W'(walk_pos_ff) + 1'b1;
   assign step_addr = wrap({1'b0, front_ff} + (IDX_W+1)'(step_off));

   assign dp_status.op_known = req_operation inside {[OP_PUSH_FRONT:OP_WALK_BACK]};
   assign dp_status.more     = walk_ff && !pos_last;

   assign wr_en   = cmd.start && is_push && !full;
   assign wr_addr = (req_operation == OP_PUSH_FRONT) ? front_dec : tail_addr;
   assign rd_en   = (cmd.start && (is_pop || is_walk) && !empty)
                 || (cmd.emit && dp_status.more);
   assign rd_addr = cmd.start ? start_addr : step_addr;

   always_comb begin
      front_in       = front_ff;
      count_in       = count_ff;
      walk_in        = walk_ff;
      walk_pos_in    = walk_pos_ff;
      pend_status_in = pend_status_ff;
      pend_mem_in    = pend_mem_ff;
      if (cmd.start) begin
         walk_pos_in    = '0;
         walk_in        = is_walk && !empty;
         pend_mem_in    = (is_pop || is_walk) && !empty;
         pend_status_in = STATUS_OK;
         case (req_operation)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               if (full) begin
                  pend_status_in = STATUS_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
                  if (req_operation == OP_PUSH_FRONT) begin
                     front_in = front_dec;
                  end
               end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
               if (empty) begin
                  pend_status_in = STATUS_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
                  if (req_operation == OP_POP_FRONT) begin
                     front_in = front_inc;
                  end
               end
            end
            OP_WALK_FWD, OP_WALK_BACK: begin
               if (empty) begin
                  pend_status_in = STATUS_EMPTY;
               end
            end
            default: begin
               pend_mem_in = 1'b0;
            end
         endcase
      end else if (cmd.emit) begin
         // advance the walk, drop the walk flag on its final word
         if (dp_status.more) begin
            walk_pos_in = walk_pos_ff + 1'b1;
         end else begin
            walk_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         walk_ff  <= 1'b0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
         walk_ff  <= walk_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_pos_ff    <= walk_pos_in;
      pend_status_ff <= pend_status_in;
      pend_mem_ff    <= pend_mem_in;
      if (cmd.start) begin
         back_ff <= (req_operation == OP_WALK_BACK);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_value_ff  <= pend_mem_ff ? rd_data_ff : '0;
         out_last_ff   <= !dp_status.more;
         out_status_ff <= pend_status_ff;
         out_count_ff  <= count_ff;
      end
   end

   assign rsp_value_res   = out_value_ff;
   assign rsp_last        = out_last_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_entry_count = out_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count beyond capacity");

   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      front_ff <= IDX_W'(CAPACITY - 1))
      else $error("front pointer outside the ring");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.start && is_push && !full |=> count_ff == $past(count_ff) + 1'b1)
      else $error("accepted push did not grow the queue");
`endif

endmodule

// ===== src/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit words with push, pop and
// ordered walks from either end.
// ----------------------------------------------------------------------------
// The block takes one operation at a time. A push, a pop, an operation that
// fails on a full or empty queue, or a walk of one entry is taken and its
// result word is loaded into the output register once that is free; no new
// request is taken before then. A walk over N stored entries holds the request
// side until its last word is loaded, one word a cycle while rsp_stall allows,
// paced by the single read port of the slot memory and its registered read
// data. The output register lets a new request be taken while the last word
// still waits on rsp_stall. Undefined codes are taken and give no word. No
// clearing pass follows reset: slots are only read after a push wrote them.
module double_ended_queue
   import dq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [OP_W-1:0]                        req_operation,
   input  logic signed [VAL_W-1:0]                req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [VAL_W-1:0]                rsp_value_res,
   output logic                                   rsp_last,
   output logic [STATUS_W-1:0]                    rsp_status,
   output logic [$clog2(CAPACITY+1)-1:0]          rsp_entry_count
);

   dq_cmd_type  cmd;
   dq_stat_type dp_status;

   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .dp_status (dp_status)
   );

   dq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .dp_status       (dp_status),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .rsp_value_res   (rsp_value_res),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

// ===== verif/double_ended_queue_tb.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the bounded double-ended queue. A driver feeds
// operation words from a pending list and a monitor predicts every result
// word from its own shadow queue, then compares each received word in order.
// Runs directed corner cases, then fill/drain sequences over four pacing
// phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
   import dq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int COUNT_W     = $clog2(DEPTH + 1);
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 40;
   localparam int PHASE_WORDS = 47;

   localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   typedef struct {
      logic [OP_W-1:0]         op;
      logic signed [VAL_W-1:0] val;
   } op_word_type;

   typedef struct {
      logic signed [VAL_W-1:0] value_res;
      logic                    last;
      logic [STATUS_W-1:0]     status;
      logic [COUNT_W-1:0]      entry_count;
   } rsp_word_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [OP_W-1:0]             req_operation = '0;
   logic signed [VAL_W-1:0]     req_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [VAL_W-1:0]     rsp_value_res;
   logic                        rsp_last;
   logic [STATUS_W-1:0]         rsp_status;
   logic [COUNT_W-1:0]          rsp_entry_count;

   op_word_type  pending_words[$];
   rsp_word_type expected_rsps[$];
   op_word_type  next_word;
   rsp_word_type oldest_rsp;

   logic signed [VAL_W-1:0] shadow_slots[DEPTH];
   int   shadow_head  = 0;
   int   shadow_count = 0;

   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic word_taken     = 1'b0;
   int   cycle_count    = 0;
   int   mismatch_count = 0;

   // stimulus-side level tracking, used only to steer fill and drain runs
   int   gen_count = 0;
   bit   filling   = 1'b1;

   double_ended_queue #(.CAPACITY(DEPTH)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value_res   (rsp_value_res),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   always #2 clock = ~clock;

   function automatic rsp_word_type make_rsp(logic signed [VAL_W-1:0] v, logic l,
                                             logic [STATUS_W-1:0] s);
      rsp_word_type r;
      r.value_res   = v;
      r.last        = l;
      r.status      = s;
      r.entry_count = COUNT_W'(shadow_count);
      return r;
   endfunction

   // apply one accepted operation to the shadow queue and queue its results
   task automatic deque_apply(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] val);
      int off;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (shadow_count >= DEPTH) begin
               expected_rsps.push_back(make_rsp('0, 1'b1, STATUS_FULL));
            end else begin
               if (op == OP_PUSH_FRONT) begin
                  shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                  shadow_slots[shadow_head] = val;
               end else begin
                  shadow_slots[(shadow_head + shadow_count) % DEPTH] = val;
               end
               shadow_count++;
               expected_rsps.push_back(make_rsp('0, 1'b1, STATUS_OK));
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (shadow_count == 0) begin
               expected_rsps.push_back(make_rsp('0, 1'b1, STATUS_EMPTY));
            end else begin
               if (op == OP_POP_FRONT) begin
                  off = shadow_head;
                  shadow_head = (shadow_head + 1) % DEPTH;
               end else begin
                  off = (shadow_head + shadow_count - 1) % DEPTH;
               end
               shadow_count--;
               expected_rsps.push_back(make_rsp(shadow_slots[off], 1'b1, STATUS_OK));
            end
         end
         OP_WALK_FWD, OP_WALK_BACK: begin
            if (shadow_count == 0) begin
               expected_rsps.push_back(make_rsp('0, 1'b1, STATUS_EMPTY));
            end else begin
               for (int i = 0; i < shadow_count; i++) begin
                  off = (op == OP_WALK_FWD) ? i : shadow_count - 1 - i;
                  expected_rsps.push_back(make_rsp(
                     shadow_slots[(shadow_head + off) % DEPTH],
                     i == shadow_count - 1, STATUS_OK));
               end
            end
         end
         default: begin
            // undefined codes give no word
         end
      endcase
   endtask

   task automatic add_word(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] val);
      op_word_type w;
      w.op  = op;
      w.val = val;
      pending_words.push_back(w);
      if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
         if (gen_count < DEPTH) gen_count++;
      end else if (op == OP_POP_FRONT || op == OP_POP_BACK) begin
         if (gen_count > 0) gen_count--;
      end
   endtask

   function automatic logic signed [VAL_W-1:0] rand_value();
      case ($urandom_range(15))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2:       return '0;
         3:       return -1;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_random_word();
      int  r;
      bit  do_push;
      logic [OP_W-1:0] op;
      r = $urandom_range(99);
      if (r < 3) begin
         op = OP_W'($urandom_range(7, 6));
      end else if (r < 15) begin
         op = $urandom_range(1) ? OP_WALK_BACK : OP_WALK_FWD;
      end else begin
         do_push = filling ? ($urandom_range(99) < 80) : ($urandom_range(99) >= 80);
         if (do_push) op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
         else         op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
      end
      add_word(op, rand_value());
      // linger a little at full and empty so overflow and underflow get hit
      if (filling && gen_count == DEPTH && $urandom_range(2) == 0) filling = 1'b0;
      if (!filling && gen_count == 0 && $urandom_range(2) == 0) filling = 1'b1;
   endtask

   // driver: change inputs on the falling edge only
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || word_taken) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_word = pending_words.pop_front();
            req_valid     <= 1'b1;
            req_operation <= next_word.op;
            req_value     <= next_word.val;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // monitor: predict on request accept, check on result accept
   always @(posedge clock) begin
      word_taken <= req_valid && !req_stall && !reset;
      if (!reset) begin
         if (req_valid && !req_stall) deque_apply(req_operation, req_value);
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result word: value_res %0d", rsp_value_res);
               mismatch_count++;
            end else begin
               oldest_rsp = expected_rsps.pop_front();
               if (rsp_value_res !== oldest_rsp.value_res) begin
                  $error("value_res: expected %0d, got %0d",
                         oldest_rsp.value_res, rsp_value_res);
                  mismatch_count++;
               end
               if (rsp_last !== oldest_rsp.last) begin
                  $error("last: expected %0d, got %0d", oldest_rsp.last, rsp_last);
                  mismatch_count++;
               end
               if (rsp_status !== oldest_rsp.status) begin
                  $error("status: expected %0d, got %0d", oldest_rsp.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_entry_count !== oldest_rsp.entry_count) begin
                  $error("entry_count: expected %0d, got %0d",
                         oldest_rsp.entry_count, rsp_entry_count);
                  mismatch_count++;
               end
            end
         end
      end
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int send_pct[4];
      int recv_pct[4];
      send_pct = '{0, 88, 0, 34};
      recv_pct = '{0, 0, 88, 34};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty queue, undefined codes, field extremes, one-entry walk
      add_word(OP_POP_FRONT, 32'sh1234_5678);
      add_word(OP_POP_BACK, -1);
      add_word(OP_WALK_FWD, '0);
      add_word(OP_WALK_BACK, VAL_MAX);
      add_word(3'd6, VAL_MAX);
      add_word(3'd7, VAL_MIN);
      add_word(OP_PUSH_FRONT, VAL_MIN);
      add_word(OP_PUSH_BACK, VAL_MAX);
      add_word(OP_PUSH_FRONT, '0);
      add_word(OP_PUSH_BACK, -1);
      add_word(OP_PUSH_FRONT, 32'sh5555_5555);
      add_word(OP_PUSH_BACK, 32'shaaaa_aaaa);
      add_word(OP_WALK_FWD, '0);
      add_word(OP_WALK_BACK, '0);
      add_word(OP_POP_FRONT, '0);
      add_word(OP_POP_BACK, '0);
      add_word(OP_WALK_FWD, -1);
      add_word(OP_POP_FRONT, '0);
      add_word(OP_POP_BACK, '0);
      add_word(OP_POP_FRONT, '0);
      add_word(OP_POP_BACK, '0);
      add_word(OP_PUSH_BACK, 32'sd7);
      add_word(OP_WALK_FWD, '0);
      add_word(OP_POP_BACK, '0);

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = send_pct[p];
         recv_stall_pct = recv_pct[p];
         for (int n = 0; n < PHASE_WORDS; n++) add_random_word();
         while (pending_words.size() != 0 || req_valid) @(posedge clock);
      end

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
